@@ hdl/hgni_pkg.sv @@
// Shared types, constants and direction tables for the hex grid neighbor index block.
// No dependencies.
package hgni_pkg;

  localparam int ROOM_W     = 20;
  localparam int CFG_W      = 11;
  localparam int DIR_W      = 3;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int GRID_RESET = 10;

  // divider pipeline: quotient bits resolved per stage
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (ROOM_W + DIV_STEPS - 1) / DIV_STEPS;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_NEXT = 2'd0,
    MODE_DIR  = 2'd1,
    MODE_OPP  = 2'd2
  } mode_e;

  typedef enum logic [DIR_W-1:0] {
    DIR_RIGHT      = 3'd0,
    DIR_RIGHT_UP   = 3'd1,
    DIR_LEFT_UP    = 3'd2,
    DIR_LEFT       = 3'd3,
    DIR_LEFT_DOWN  = 3'd4,
    DIR_RIGHT_DOWN = 3'd5
  } dir_e;

  // two's complement delta in 3 bits
  typedef logic [2:0] delta_t;

  function automatic logic dir_valid(logic [DIR_W-1:0] d);
    logic v;
    case (dir_e'(d))
      DIR_RIGHT, DIR_RIGHT_UP, DIR_LEFT_UP,
      DIR_LEFT, DIR_LEFT_DOWN, DIR_RIGHT_DOWN: v = 1'b1;
      default: v = 1'b0;
    endcase
    return v;
  endfunction

  function automatic delta_t dir_dx(logic [DIR_W-1:0] d);
    delta_t r;
    case (dir_e'(d))
      DIR_RIGHT:      r = 3'b010;
      DIR_RIGHT_UP:   r = 3'b001;
      DIR_LEFT_UP:    r = 3'b111;
      DIR_LEFT:       r = 3'b110;
      DIR_LEFT_DOWN:  r = 3'b111;
      DIR_RIGHT_DOWN: r = 3'b001;
      default:        r = 3'b000;
    endcase
    return r;
  endfunction

  function automatic delta_t dir_dy(logic [DIR_W-1:0] d);
    delta_t r;
    case (dir_e'(d))
      DIR_RIGHT:      r = 3'b000;
      DIR_RIGHT_UP:   r = 3'b001;
      DIR_LEFT_UP:    r = 3'b001;
      DIR_LEFT:       r = 3'b000;
      DIR_LEFT_DOWN:  r = 3'b111;
      DIR_RIGHT_DOWN: r = 3'b111;
      default:        r = 3'b000;
    endcase
    return r;
  endfunction

  function automatic logic [DIR_W-1:0] dir_opposite(logic [DIR_W-1:0] d);
    dir_e r;
    case (dir_e'(d))
      DIR_RIGHT:      r = DIR_LEFT;
      DIR_RIGHT_UP:   r = DIR_LEFT_DOWN;
      DIR_LEFT_UP:    r = DIR_RIGHT_DOWN;
      DIR_LEFT:       r = DIR_RIGHT;
      DIR_LEFT_DOWN:  r = DIR_RIGHT_UP;
      DIR_RIGHT_DOWN: r = DIR_LEFT_UP;
      default:        r = DIR_RIGHT;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/hgni_div.sv @@
// Pipelined restoring divider: room index by grid width, DIV_STEPS quotient bits per stage.
// Depends on hgni_pkg. Stage registers advance on their own enable bit.
module hgni_div #(
  parameter int DIV_W = $clog2(hgni_pkg::MAX_WIDTH + 1)
) (
  input  logic                             clk_i,
  input  logic [hgni_pkg::DIV_STAGES-1:0]  en_i,
  input  logic [hgni_pkg::ROOM_W-1:0]      dividend_i,
  input  logic [DIV_W-1:0]                 divisor_i,
  output logic [hgni_pkg::ROOM_W-1:0]      quot_o,
  output logic [DIV_W-1:0]                 rem_o
);

  localparam int RW    = hgni_pkg::ROOM_W;
  localparam int NS    = hgni_pkg::DIV_STAGES;
  localparam int STEPS = hgni_pkg::DIV_STEPS;

  logic [DIV_W-1:0] rem_q [NS];
  logic [RW-1:0]    nq_q  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int NSTEP = (k == NS - 1) ? RW - STEPS * (NS - 1) : STEPS;

    logic [DIV_W-1:0] rem_in;
    logic [DIV_W-1:0] rem_nx;
    logic [RW-1:0]    nq_in;
    logic [RW-1:0]    nq_nx;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = dividend_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign nq_in  = nq_q[k-1];
    end

    // nq shifts dividend bits out at the top and quotient bits in at the bottom
    always_comb begin
      logic [DIV_W:0] t;
      logic [DIV_W:0] dv;
      t      = '0;
      dv     = {1'b0, divisor_i};
      rem_nx = rem_in;
      nq_nx  = nq_in;
      for (int j = 0; j < NSTEP; j++) begin
        t     = {rem_nx, nq_nx[RW-1]};
        nq_nx = {nq_nx[RW-2:0], 1'b0};
        if (t >= dv) begin
          t        = t - dv;
          nq_nx[0] = 1'b1;
        end
        rem_nx = t[DIV_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k] <= rem_nx;
        nq_q[k]  <= nq_nx;
      end
    end
  end

  assign quot_o = nq_q[NS-1];
  assign rem_o  = rem_q[NS-1];

endmodule

@@ hdl/hex_grid_neighbor_index.sv @@
// Hex grid neighbor index: next room, direction between rooms, opposite direction.
// The result is registered on the output after the request passes through
// 5 divider stages, a coordinate stage, a multiply stage and an output stage.
// Throughput: one request per cycle while the output is not stalled; the pipeline closes bubbles under stall.
// Reset: pipeline emptied, grid width and height return to 10 by 10.
// Depends on hgni_pkg and hgni_div.
module hex_grid_neighbor_index #(
  parameter int MAX_WIDTH  = hgni_pkg::MAX_WIDTH,
  parameter int MAX_HEIGHT = hgni_pkg::MAX_HEIGHT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  input  logic                             cfg_we_i,
  input  logic [hgni_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hgni_pkg::CFG_W-1:0]       cfg_wdata_i,

  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [hgni_pkg::MODE_W-1:0]      mode_i,
  input  logic [hgni_pkg::ROOM_W-1:0]      from_room_i,
  input  logic [hgni_pkg::ROOM_W-1:0]      to_room_i,
  input  logic [hgni_pkg::DIR_W-1:0]       dir_in_i,

  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [hgni_pkg::ROOM_W-1:0]      room_out_o,
  output logic [hgni_pkg::DIR_W-1:0]       dir_out_o,
  output logic                             found_o
);

  localparam int RW  = hgni_pkg::ROOM_W;
  localparam int DW  = hgni_pkg::DIR_W;
  localparam int NS  = hgni_pkg::DIV_STAGES;
  localparam int NST = NS + 3;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int XW  = WW + 3;
  localparam int YW  = RW + 2;
  localparam int PW  = WW + HW;

  // configuration
  logic [hgni_pkg::CFG_W-1:0] grid_width_q;
  logic [hgni_pkg::CFG_W-1:0] grid_height_q;
  logic [WW-1:0]              w_eff;
  logic [HW-1:0]              h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= hgni_pkg::CFG_W'(hgni_pkg::GRID_RESET);
      grid_height_q <= hgni_pkg::CFG_W'(hgni_pkg::GRID_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hgni_pkg::CFG_GRID_WIDTH:  grid_width_q  <= cfg_wdata_i;
        hgni_pkg::CFG_GRID_HEIGHT: grid_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(grid_width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(grid_width_q);
    end
    if (grid_height_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(grid_height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(grid_height_q);
    end
  end

  // stage valids and per-stage advance
  logic [NST-1:0] v_q;
  logic [NST-1:0] v_d;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v_q[NST-1] || !out_stall_i;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  assign v_d        = {v_q[NST-2:0], in_valid_i};
  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) begin
          v_q[i] <= v_d[i];
        end
      end
    end
  end

  // side band through the divider stages
  logic [hgni_pkg::MODE_W-1:0] mode_q [NS];
  logic [DW-1:0]               dir_q  [NS];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      mode_q[0] <= mode_i;
      dir_q[0]  <= dir_in_i;
    end
    for (int i = 1; i < NS; i++) begin
      if (en[i]) begin
        mode_q[i] <= mode_q[i-1];
        dir_q[i]  <= dir_q[i-1];
      end
    end
  end

  // row and column of both rooms
  logic [RW-1:0] frow;
  logic [RW-1:0] trow;
  logic [WW-1:0] fcol;
  logic [WW-1:0] tcol;

  hgni_div #(
    .DIV_W (WW)
  ) u_div_from (
    .clk_i      (clk_i),
    .en_i       (en[NS-1:0]),
    .dividend_i (from_room_i),
    .divisor_i  (w_eff),
    .quot_o     (frow),
    .rem_o      (fcol)
  );

  hgni_div #(
    .DIV_W (WW)
  ) u_div_to (
    .clk_i      (clk_i),
    .en_i       (en[NS-1:0]),
    .dividend_i (to_room_i),
    .divisor_i  (w_eff),
    .quot_o     (trow),
    .rem_o      (tcol)
  );

  // coordinate stage
  logic          found_e_d;
  logic [DW-1:0] dir_e_d;
  logic [WW-1:0] ncol_e_d;
  logic [HW-1:0] nhy_e_d;
  logic          found_e_q;
  logic [DW-1:0] dir_e_q;
  logic [WW-1:0] ncol_e_q;
  logic [HW-1:0] nhy_e_q;

  always_comb begin
    logic [WW:0]             fhx;
    logic [WW:0]             thx;
    logic [XW-1:0]           nhx;
    logic [YW-1:0]           nhy;
    logic [WW+1:0]           dxd;
    logic [RW:0]             dyd;
    hgni_pkg::delta_t        ddx;
    hgni_pkg::delta_t        ddy;
    logic                    dok;
    fhx       = {fcol, frow[0]};
    thx       = {tcol, trow[0]};
    dok       = hgni_pkg::dir_valid(dir_q[NS-1]);
    ddx       = hgni_pkg::dir_dx(dir_q[NS-1]);
    ddy       = hgni_pkg::dir_dy(dir_q[NS-1]);
    nhx       = {2'b00, fhx} + {{(XW-3){ddx[2]}}, ddx};
    nhy       = {2'b00, frow} + {{(YW-3){ddy[2]}}, ddy};
    dxd       = {1'b0, thx} - {1'b0, fhx};
    dyd       = {1'b0, trow} - {1'b0, frow};
    found_e_d = 1'b0;
    dir_e_d   = '0;
    ncol_e_d  = '0;
    nhy_e_d   = '0;
    case (hgni_pkg::mode_e'(mode_q[NS-1]))
      hgni_pkg::MODE_NEXT: begin
        if (dok && !nhx[XW-1] && !nhy[YW-1] && (nhy < YW'(h_eff)) &&
            (nhx[WW+1:1] < {1'b0, w_eff})) begin
          found_e_d = 1'b1;
          ncol_e_d  = nhx[WW:1];
          nhy_e_d   = nhy[HW-1:0];
        end
      end
      hgni_pkg::MODE_DIR: begin
        for (int k = 5; k >= 0; k--) begin
          ddx = hgni_pkg::dir_dx(DW'(k));
          ddy = hgni_pkg::dir_dy(DW'(k));
          if ((dxd == {{(WW-1){ddx[2]}}, ddx}) && (dyd == {{(RW-2){ddy[2]}}, ddy})) begin
            found_e_d = 1'b1;
            dir_e_d   = DW'(k);
          end
        end
      end
      hgni_pkg::MODE_OPP: begin
        if (dok) begin
          found_e_d = 1'b1;
          dir_e_d   = hgni_pkg::dir_opposite(dir_q[NS-1]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[NS]) begin
      found_e_q <= found_e_d;
      dir_e_q   <= dir_e_d;
      ncol_e_q  <= ncol_e_d;
      nhy_e_q   <= nhy_e_d;
    end
  end

  // multiply stage
  logic [PW-1:0] prod_q;
  logic [WW-1:0] col_m_q;
  logic          found_m_q;
  logic [DW-1:0] dir_m_q;

  always_ff @(posedge clk_i) begin
    if (en[NS+1]) begin
      prod_q    <= PW'(nhy_e_q) * PW'(w_eff);
      col_m_q   <= ncol_e_q;
      found_m_q <= found_e_q;
      dir_m_q   <= dir_e_q;
    end
  end

  // output stage
  logic [RW-1:0] room_q;
  logic [DW-1:0] dir_o_q;
  logic          found_o_q;

  always_ff @(posedge clk_i) begin
    if (en[NS+2]) begin
      room_q    <= RW'(prod_q) + RW'(col_m_q);
      dir_o_q   <= dir_m_q;
      found_o_q <= found_m_q;
    end
  end

  assign out_valid_o = v_q[NST-1];
  assign room_out_o  = room_q;
  assign dir_out_o   = dir_o_q;
  assign found_o     = found_o_q;

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> (room_out_o == '0) && (dir_out_o == '0))
    else $error("miss result carries nonzero fields");

  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> (dir_out_o <= DW'(hgni_pkg::DIR_RIGHT_DOWN)))
    else $error("direction out of range");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q) && out_stall_i)
    else $error("input stalled with a free stage");
`endif

endmodule

@@ tb/hgni_checker.sv @@
// Scoreboard for hex_grid_neighbor_index: follows the register writes, predicts each
// accepted request and compares the results in order. Depends on hgni_pkg.
`timescale 1ns / 1ps
module hgni_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hgni_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hgni_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [hgni_pkg::MODE_W-1:0]    mode_i,
  input  logic [hgni_pkg::ROOM_W-1:0]    from_room_i,
  input  logic [hgni_pkg::ROOM_W-1:0]    to_room_i,
  input  logic [hgni_pkg::DIR_W-1:0]     dir_in_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [hgni_pkg::ROOM_W-1:0]    room_out_i,
  input  logic [hgni_pkg::DIR_W-1:0]     dir_out_i,
  input  logic                           found_i,
  output int                             pending_o,
  output int                             errors_o
);

  localparam int RW = hgni_pkg::ROOM_W;
  localparam int DW = hgni_pkg::DIR_W;
  localparam int CW = hgni_pkg::CFG_W;
  localparam int MW = hgni_pkg::MODE_W;

  typedef struct packed {
    logic [RW-1:0] room;
    logic [DW-1:0] dir;
    logic          found;
  } neighbor_result_t;

  logic [CW-1:0]    grid_w_reg;
  logic [CW-1:0]    grid_h_reg;
  neighbor_result_t expected_results[$];
  int               mismatches;

  function automatic longint clamp_dim(logic [CW-1:0] v, int maxv);
    longint d;
    d = longint'(v);
    if (d < 1) d = 1;
    if (d > maxv) d = maxv;
    return d;
  endfunction

  function automatic longint hex_dx(hgni_pkg::dir_e d);
    longint v;
    case (d)
      hgni_pkg::DIR_RIGHT:                          v = 2;
      hgni_pkg::DIR_RIGHT_UP, hgni_pkg::DIR_RIGHT_DOWN: v = 1;
      hgni_pkg::DIR_LEFT_UP, hgni_pkg::DIR_LEFT_DOWN:   v = -1;
      hgni_pkg::DIR_LEFT:                           v = -2;
      default:                                      v = 0;
    endcase
    return v;
  endfunction

  function automatic longint hex_dy(hgni_pkg::dir_e d);
    longint v;
    case (d)
      hgni_pkg::DIR_RIGHT_UP, hgni_pkg::DIR_LEFT_UP:     v = 1;
      hgni_pkg::DIR_LEFT_DOWN, hgni_pkg::DIR_RIGHT_DOWN: v = -1;
      default:                                           v = 0;
    endcase
    return v;
  endfunction

  function automatic neighbor_result_t predict_neighbor(
    logic [MW-1:0] mode, logic [RW-1:0] from_room, logic [RW-1:0] to_room,
    logic [DW-1:0] dir, logic [CW-1:0] w_reg, logic [CW-1:0] h_reg);
    longint w, h, fx, fy, tx, ty, col;
    neighbor_result_t r;
    w = clamp_dim(w_reg, hgni_pkg::MAX_WIDTH);
    h = clamp_dim(h_reg, hgni_pkg::MAX_HEIGHT);
    r = '0;
    // doubled coordinates: x = 2*col + row parity
    fy = longint'(from_room) / w;
    fx = 2 * (longint'(from_room) % w) + (fy & 1);
    ty = longint'(to_room) / w;
    tx = 2 * (longint'(to_room) % w) + (ty & 1);
    case (mode)
      hgni_pkg::MODE_NEXT: begin
        if (dir <= hgni_pkg::DIR_RIGHT_DOWN) begin
          fx = fx + hex_dx(hgni_pkg::dir_e'(dir));
          fy = fy + hex_dy(hgni_pkg::dir_e'(dir));
          if (fx >= 0 && fy >= 0 && fy < h) begin
            col = fx / 2;
            if (col < w) begin
              r.room  = RW'(fy * w + col);
              r.found = 1'b1;
            end
          end
        end
      end
      hgni_pkg::MODE_DIR: begin
        for (int k = 0; k <= int'(hgni_pkg::DIR_RIGHT_DOWN); k++) begin
          if (!r.found && tx == fx + hex_dx(hgni_pkg::dir_e'(DW'(k)))
              && ty == fy + hex_dy(hgni_pkg::dir_e'(DW'(k)))) begin
            r.dir   = DW'(k);
            r.found = 1'b1;
          end
        end
      end
      hgni_pkg::MODE_OPP: begin
        if (dir <= hgni_pkg::DIR_RIGHT_DOWN) begin
          r.dir   = DW'((int'(dir) + 3) % 6);
          r.found = 1'b1;
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, neighbor_result_t exp_r);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: exp room %0d dir %0d found %0d, got room %0d dir %0d found %0d",
               $realtime, what, exp_r.room, exp_r.dir, exp_r.found,
               room_out_i, dir_out_i, found_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    neighbor_result_t exp_r;
    neighbor_result_t pred_r;
    if (!rst_ni) begin
      grid_w_reg = CW'(hgni_pkg::GRID_RESET);
      grid_h_reg = CW'(hgni_pkg::GRID_RESET);
      expected_results.delete();
      mismatches = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hgni_pkg::CFG_GRID_WIDTH:  grid_w_reg = cfg_wdata_i;
          hgni_pkg::CFG_GRID_HEIGHT: grid_h_reg = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        pred_r = predict_neighbor(mode_i, from_room_i, to_room_i,
                                  dir_in_i, grid_w_reg, grid_h_reg);
        expected_results = {expected_results, pred_r};
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request pending", '0);
        end else begin
          exp_r = expected_results.pop_front();
          if (room_out_i !== exp_r.room || dir_out_i !== exp_r.dir
              || found_i !== exp_r.found)
            report_mismatch("result mismatch", exp_r);
        end
      end
      pending_o <= expected_results.size();
      errors_o  <= mismatches;
    end
  end

endmodule

@@ tb/hex_grid_neighbor_index_test.sv @@
// Top of the hex_grid_neighbor_index regression (depends on it, hgni_pkg, hgni_checker):
// directed and random requests over several grid sizes with random idling on both sides.
`timescale 1ns / 1ps
module hex_grid_neighbor_index_test;

  localparam int MW = hgni_pkg::MODE_W;
  localparam int RW = hgni_pkg::ROOM_W;
  localparam int DW = hgni_pkg::DIR_W;
  localparam int CW = hgni_pkg::CFG_W;
  localparam int IW = hgni_pkg::CFG_IDX_W;

  localparam logic [MW-1:0] MODE_UNUSED = 2'd3;
  localparam int PHASES    = 10;
  localparam int PHASE_REQ = 125;

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic [IW-1:0] cfg_idx;
  logic [CW-1:0] cfg_wdata;
  logic          in_valid;
  logic          in_stall;
  logic [MW-1:0] mode;
  logic [RW-1:0] from_room;
  logic [RW-1:0] to_room;
  logic [DW-1:0] dir_in;
  logic          out_valid;
  logic          out_stall;
  logic [RW-1:0] room_out;
  logic [DW-1:0] dir_out;
  logic          found;
  int            pending;
  int            errors;
  bit            tx_calm;
  bit            rx_calm;

  hex_grid_neighbor_index u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .mode_i      (mode),
    .from_room_i (from_room),
    .to_room_i   (to_room),
    .dir_in_i    (dir_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .room_out_o  (room_out),
    .dir_out_o   (dir_out),
    .found_o     (found)
  );

  hgni_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .mode_i      (mode),
    .from_room_i (from_room),
    .to_room_i   (to_room),
    .dir_in_i    (dir_in),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .room_out_i  (room_out),
    .dir_out_i   (dir_out),
    .found_i     (found),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic send_request(logic [MW-1:0] m, logic [RW-1:0] f,
                              logic [RW-1:0] t, logic [DW-1:0] d);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_calm = ~tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    from_room <= f;
    to_room   <= t;
    dir_in    <= d;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off new requests until every result is back
  task automatic drain_requests();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic set_grid(logic [CW-1:0] w, logic [CW-1:0] h);
    cfg_we    <= 1'b1;
    cfg_idx   <= hgni_pkg::CFG_GRID_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_idx   <= hgni_pkg::CFG_GRID_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_random(int eff_w, int eff_h);
    logic [MW-1:0] m;
    logic [RW-1:0] f, t;
    logic [DW-1:0] d;
    int p, row, col, delta;
    p = $urandom_range(0, 99);
    if (p < 45)      m = hgni_pkg::MODE_NEXT;
    else if (p < 80) m = hgni_pkg::MODE_DIR;
    else if (p < 95) m = hgni_pkg::MODE_OPP;
    else             m = MODE_UNUSED;
    p = $urandom_range(0, 99);
    if (p < 70) begin
      f = RW'($urandom_range(0, eff_w * eff_h - 1));
    end else if (p < 88) begin
      case ($urandom_range(0, 3))
        0: row = 0;
        1: row = (eff_h > 1) ? 1 : 0;
        2: row = eff_h - 1;
        default: row = $urandom_range(0, eff_h - 1);
      endcase
      case ($urandom_range(0, 3))
        0: col = 0;
        1: col = (eff_w > 1) ? 1 : 0;
        2: col = eff_w - 1;
        default: col = $urandom_range(0, eff_w - 1);
      endcase
      f = RW'(row * eff_w + col);
    end else begin
      f = RW'($urandom);
    end
    p = $urandom_range(0, 99);
    if (m == hgni_pkg::MODE_DIR && p < 65) begin
      case ($urandom_range(0, 7))
        0: delta = 1;
        1: delta = -1;
        2: delta = eff_w;
        3: delta = -eff_w;
        4: delta = eff_w - 1;
        5: delta = eff_w + 1;
        6: delta = -eff_w - 1;
        default: delta = 1 - eff_w;
      endcase
      t = RW'(int'(f) + delta);
    end else if (m == hgni_pkg::MODE_DIR && p < 75) begin
      t = f;
    end else begin
      t = RW'($urandom);
    end
    d = ($urandom_range(0, 9) < 9) ? DW'($urandom_range(0, 5)) : DW'($urandom_range(6, 7));
    send_request(m, f, t, d);
  endtask

  // receiver: random stall before each result, with calm stretches
  initial begin
    int gap;
    out_stall = 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0) rx_calm = ~rx_calm;
      gap = rx_calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    logic [CW-1:0] w_cfg [PHASES];
    logic [CW-1:0] h_cfg [PHASES];
    int eff_w, eff_h;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = hgni_pkg::CFG_GRID_WIDTH;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    mode      = hgni_pkg::MODE_NEXT;
    from_room = '0;
    to_room   = '0;
    dir_in    = hgni_pkg::DIR_RIGHT;
    tx_calm   = 1'b0;
    rx_calm   = 1'b0;
    w_cfg = '{11'd0, 11'd1, 11'd2047, 11'd1024, 11'd1, 11'd1024, 11'd3,
              CW'($urandom_range(0, 2047)), CW'($urandom_range(1, 64)), 11'd10};
    h_cfg = '{11'd0, 11'd1, 11'd2047, 11'd1024, 11'd1024, 11'd1, 11'd7,
              CW'($urandom_range(0, 2047)), CW'($urandom_range(1, 64)), 11'd10};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, on the 10 by 10 reset grid
    send_request(hgni_pkg::MODE_NEXT, 20'd0, 20'd0, hgni_pkg::DIR_RIGHT);
    send_request(hgni_pkg::MODE_NEXT, 20'd0, 20'd0, hgni_pkg::DIR_LEFT);
    send_request(hgni_pkg::MODE_NEXT, 20'd0, 20'd0, hgni_pkg::DIR_LEFT_DOWN);
    send_request(hgni_pkg::MODE_NEXT, 20'd0, 20'd0, hgni_pkg::DIR_RIGHT_UP);
    send_request(hgni_pkg::MODE_NEXT, 20'd99, 20'd0, hgni_pkg::DIR_RIGHT);
    send_request(hgni_pkg::MODE_NEXT, 20'd99, 20'd0, hgni_pkg::DIR_LEFT_UP);
    send_request(hgni_pkg::MODE_NEXT, 20'd10, 20'd0, hgni_pkg::DIR_LEFT_UP);
    // odd row, column zero: x of -1 is off the grid
    send_request(hgni_pkg::MODE_NEXT, 20'd10, 20'd0, hgni_pkg::DIR_LEFT);
    send_request(hgni_pkg::MODE_NEXT, 20'd5, 20'd0, DW'(6));
    send_request(hgni_pkg::MODE_NEXT, 20'd5, 20'd0, DW'(7));
    send_request(hgni_pkg::MODE_NEXT, 20'hFFFFF, 20'hFFFFF, hgni_pkg::DIR_RIGHT_DOWN);
    send_request(hgni_pkg::MODE_DIR, 20'd0, 20'd1, hgni_pkg::DIR_RIGHT);
    send_request(hgni_pkg::MODE_DIR, 20'd10, 20'd0, hgni_pkg::DIR_RIGHT);
    send_request(hgni_pkg::MODE_DIR, 20'd5, 20'd5, hgni_pkg::DIR_RIGHT);
    send_request(hgni_pkg::MODE_DIR, 20'd0, 20'hFFFFF, DW'(7));
    for (int d = 0; d < 8; d++)
      send_request(hgni_pkg::MODE_OPP, 20'd0, 20'd0, DW'(d));
    send_request(MODE_UNUSED, 20'hFFFFF, 20'hFFFFF, DW'(7));
    drain_requests();

    for (int ph = 0; ph < PHASES; ph++) begin
      set_grid(w_cfg[ph], h_cfg[ph]);
      eff_w = (w_cfg[ph] == 0) ? 1 :
              ((w_cfg[ph] > hgni_pkg::MAX_WIDTH) ? hgni_pkg::MAX_WIDTH : w_cfg[ph]);
      eff_h = (h_cfg[ph] == 0) ? 1 :
              ((h_cfg[ph] > hgni_pkg::MAX_HEIGHT) ? hgni_pkg::MAX_HEIGHT : h_cfg[ph]);
      repeat (PHASE_REQ) send_random(eff_w, eff_h);
      drain_requests();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("hex_grid_neighbor_index regression: pass");
    else
      $display("hex_grid_neighbor_index regression: fail");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("hex_grid_neighbor_index regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
hdl/hgni_pkg.sv
hdl/hgni_div.sv
hdl/hex_grid_neighbor_index.sv
tb/hgni_checker.sv
tb/hex_grid_neighbor_index_test.sv
